[design/v3alu_pkg.sv]
// ----------------------------------------------------------------------------
// v3alu_pkg
// Shared types and constants for the three-component vector ALU.
// ----------------------------------------------------------------------------
package v3alu_pkg;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_NEG   = 3'd2,
        OP_SCALE = 3'd3,
        OP_DOT   = 3'd4,
        OP_DIV   = 3'd5,
        OP_CROSS = 3'd6,
        OP_NORM  = 3'd7
    } op_t;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned ROOT_W = 32;
    localparam int unsigned RAD_W  = 64;
    localparam int unsigned DEN_W  = 33;
    localparam int unsigned WIDE_W = 72;

    localparam logic [WORD_W-1:0] S32_MAX = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] S32_MIN = 32'h8000_0000;

    typedef struct packed {
        logic                   vld;
        op_t                    op;
        logic [2:0][WORD_W-1:0] a;
        logic [WORD_W-1:0]      sc;
        logic [2:0][WORD_W-1:0] r;
        logic [WORD_W-1:0]      dot;
        logic                   ov;
        logic                   lz;
    } side_t;

    // {overflow, value}: clamp a wide signed value to 32 bits
    function automatic logic [WORD_W:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic in_range;
        in_range = (&v[WIDE_W-1:WORD_W-1]) | ~(|v[WIDE_W-1:WORD_W-1]);
        if (in_range) begin
            sat32 = {1'b0, v[WORD_W-1:0]};
        end else begin
            sat32 = {1'b1, v[WIDE_W-1] ? S32_MIN : S32_MAX};
        end
    endfunction

endpackage

[design/v3alu_sqrt.sv]
// ----------------------------------------------------------------------------
// v3alu_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module v3alu_sqrt (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [v3alu_pkg::RAD_W-1:0]    rad_in,
    output logic [v3alu_pkg::ROOT_W-1:0]   root_out
);

    localparam int unsigned RW  = v3alu_pkg::ROOT_W;
    localparam int unsigned DW  = v3alu_pkg::RAD_W;
    localparam int unsigned REM = RW + 4;

    logic [REM-1:0] rem_reg  [RW-1];
    logic [DW-1:0]  rad_reg  [RW-1];
    logic [RW-1:0]  root_reg [RW];

    for (genvar i = 0; i < RW; i++) begin : g_stage
        logic [REM-1:0] rem_in;
        logic [REM-1:0] rem_sh;
        logic [REM-1:0] trial;
        logic [RW-1:0]  root_in;
        logic [DW-1:0]  rad_w;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_w   = rad_in;
        end else begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rad_w   = rad_reg[i-1];
        end

        assign rem_sh = {rem_in[REM-3:0], rad_w[DW-1 -: 2]};
        assign trial  = REM'({root_in, 2'b01});

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_sh >= trial) begin
                    root_reg[i] <= {root_in[RW-2:0], 1'b1};
                end else begin
                    root_reg[i] <= {root_in[RW-2:0], 1'b0};
                end
            end
        end

        if (i < RW - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= (rem_sh >= trial) ? (rem_sh - trial) : rem_sh;
                    rad_reg[i] <= {rad_w[DW-3:0], 2'b00};
                end
            end
        end
    end

    assign root_out = root_reg[RW-1];

endmodule

[design/v3alu_div.sv]
// ----------------------------------------------------------------------------
// v3alu_div
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module v3alu_div #(
    parameter int unsigned NUM_W = 48
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [NUM_W-1:0]              num_in,
    input  logic [v3alu_pkg::DEN_W-1:0]   den_in,
    output logic [NUM_W-1:0]              quo_out
);

    localparam int unsigned DN = v3alu_pkg::DEN_W;

    logic [DN-1:0]    rem_reg [NUM_W-1];
    logic [DN-1:0]    den_reg [NUM_W-1];
    logic [NUM_W-1:0] n_reg   [NUM_W];

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic [DN-1:0]    rem_in;
        logic [DN-1:0]    den_w;
        logic [NUM_W-1:0] n_in;
        logic [DN:0]      rem_sh;
        logic             fits;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign den_w  = den_in;
            assign n_in   = num_in;
        end else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign den_w  = den_reg[i-1];
            assign n_in   = n_reg[i-1];
        end

        assign rem_sh = {rem_in, n_in[NUM_W-1]};
        assign fits   = rem_sh >= {1'b0, den_w};

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[i] <= {n_in[NUM_W-2:0], fits};
            end
        end

        if (i < NUM_W - 1) begin : g_carry
            logic [DN:0] rem_diff;
            assign rem_diff = rem_sh - {1'b0, den_w};
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= fits ? rem_diff[DN-1:0] : rem_sh[DN-1:0];
                    den_reg[i] <= den_w;
                end
            end
        end
    end

    assign quo_out = n_reg[NUM_W-1];

endmodule

[design/vector3_alu.sv]
// ----------------------------------------------------------------------------
// vector3_alu
// Three-component vector ALU in signed fixed point with saturation.
// ----------------------------------------------------------------------------
// One word is accepted per cycle and one result word leaves per cycle while
// the output is not stalled. Every operation takes the same path: three
// front stages (capture, multiply, combine), a 32-stage square root, one
// divisor setup stage, a (32 + FRAC_BITS)-stage divider and the output
// register. The whole pipeline advances together; s_axis_tready drops only
// while a result sits in the output register and m_axis_tready is low.
module vector3_alu #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [223:0] s_axis_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
    input  logic [2:0]   s_axis_tuser,   // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // r_x, r_y, r_z, dot_out
    output logic [1:0]   m_axis_tuser    // overflow_flag, div_zero_flag
);

    localparam int unsigned W     = v3alu_pkg::WORD_W;
    localparam int unsigned WW    = v3alu_pkg::WIDE_W;
    localparam int unsigned RW    = v3alu_pkg::ROOT_W;
    localparam int unsigned DN    = v3alu_pkg::DEN_W;
    localparam int unsigned NUM_W = W + FRAC_BITS;

    typedef logic signed [WW-1:0] wide_t;

    logic ce;

    // capture stage
    logic                   in_vld_reg;
    v3alu_pkg::op_t         in_op_reg;
    logic signed [W-1:0]    in_a_reg [3];
    logic signed [W-1:0]    in_b_reg [3];
    logic signed [W-1:0]    in_s_reg;

    // multiply stage
    logic signed [W-1:0]    mul_x [6];
    logic signed [W-1:0]    mul_y [6];
    logic signed [2*W-1:0]  prod_next [6];
    logic                   p1_vld_reg;
    v3alu_pkg::op_t         p1_op_reg;
    logic signed [W-1:0]    p1_a_reg [3];
    logic signed [W-1:0]    p1_b_reg [3];
    logic signed [W-1:0]    p1_s_reg;
    logic signed [2*W-1:0]  p1_prod_reg [6];

    // combine stage
    wide_t                  wide_r [3];
    wide_t                  wide_dot;
    logic [W:0]             sat_r [3];
    logic [W:0]             sat_dot;
    v3alu_pkg::side_t       side2_next;
    v3alu_pkg::side_t       side2_reg;
    logic [v3alu_pkg::RAD_W-1:0] rad_next;
    logic [v3alu_pkg::RAD_W-1:0] rad_reg;

    // square root and divisor setup
    logic [RW-1:0]          root;
    v3alu_pkg::side_t       sidea_reg [RW];
    v3alu_pkg::side_t       sided_next;
    v3alu_pkg::side_t       sided_reg;
    logic [W-1:0]           a_abs [3];
    logic [W-1:0]           s_abs;
    logic [NUM_W-1:0]       num_next [3];
    logic [NUM_W-1:0]       num_reg [3];
    logic [DN-1:0]          den_next;
    logic [DN-1:0]          den_reg;

    // divide and output
    logic [NUM_W-1:0]       quo [3];
    v3alu_pkg::side_t       sideb_reg [NUM_W];
    v3alu_pkg::side_t       fin;
    logic                   q_neg;
    logic [2:0]             q_ov;
    logic [2:0][W-1:0]      q_val;
    logic [2:0][W-1:0]      r_next;
    logic                   ov_next;
    logic                   dz_next;
    logic                   m_vld_reg;
    logic [2:0][W-1:0]      m_r_reg;
    logic [W-1:0]           m_dot_reg;
    logic                   m_ov_reg;
    logic                   m_dz_reg;

    assign ce            = !m_vld_reg || m_axis_tready;
    assign s_axis_tready = ce;

    // ---------------- capture ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (ce) begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            in_op_reg <= v3alu_pkg::op_t'(s_axis_tuser);
            for (int k = 0; k < 3; k++) begin
                in_a_reg[k] <= s_axis_tdata[k*W +: W];
                in_b_reg[k] <= s_axis_tdata[(k+3)*W +: W];
            end
            in_s_reg <= s_axis_tdata[6*W +: W];
        end
    end

    // ---------------- multiply ----------------
    always_comb begin
        mul_x[3] = in_a_reg[0];
        mul_y[3] = in_b_reg[2];
        mul_x[4] = in_a_reg[0];
        mul_y[4] = in_b_reg[1];
        mul_x[5] = in_a_reg[1];
        mul_y[5] = in_b_reg[0];
        case (in_op_reg)
            v3alu_pkg::OP_SCALE: begin
                for (int k = 0; k < 3; k++) begin
                    mul_x[k] = in_a_reg[k];
                    mul_y[k] = in_s_reg;
                end
            end
            v3alu_pkg::OP_NORM: begin
                for (int k = 0; k < 3; k++) begin
                    mul_x[k] = in_a_reg[k];
                    mul_y[k] = in_a_reg[k];
                end
            end
            v3alu_pkg::OP_CROSS: begin
                mul_x[0] = in_a_reg[1];
                mul_y[0] = in_b_reg[2];
                mul_x[1] = in_a_reg[2];
                mul_y[1] = in_b_reg[1];
                mul_x[2] = in_a_reg[2];
                mul_y[2] = in_b_reg[0];
            end
            default: begin
                for (int k = 0; k < 3; k++) begin
                    mul_x[k] = in_a_reg[k];
                    mul_y[k] = in_b_reg[k];
                end
            end
        endcase
        for (int k = 0; k < 6; k++) begin
            prod_next[k] = mul_x[k] * mul_y[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (ce) begin
            p1_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p1_op_reg <= in_op_reg;
            p1_s_reg  <= in_s_reg;
            for (int k = 0; k < 3; k++) begin
                p1_a_reg[k] <= in_a_reg[k];
                p1_b_reg[k] <= in_b_reg[k];
            end
            for (int k = 0; k < 6; k++) begin
                p1_prod_reg[k] <= prod_next[k];
            end
        end
    end

    // ---------------- combine ----------------
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            wide_r[k] = '0;
        end
        wide_dot = '0;
        case (p1_op_reg)
            v3alu_pkg::OP_ADD: begin
                for (int k = 0; k < 3; k++) begin
                    wide_r[k] = wide_t'(p1_a_reg[k]) + wide_t'(p1_b_reg[k]);
                end
            end
            v3alu_pkg::OP_SUB: begin
                for (int k = 0; k < 3; k++) begin
                    wide_r[k] = wide_t'(p1_a_reg[k]) - wide_t'(p1_b_reg[k]);
                end
            end
            v3alu_pkg::OP_NEG: begin
                for (int k = 0; k < 3; k++) begin
                    wide_r[k] = -wide_t'(p1_a_reg[k]);
                end
            end
            v3alu_pkg::OP_SCALE: begin
                for (int k = 0; k < 3; k++) begin
                    wide_r[k] = wide_t'(p1_prod_reg[k]) >>> FRAC_BITS;
                end
            end
            v3alu_pkg::OP_DOT: begin
                wide_dot = (wide_t'(p1_prod_reg[0]) + wide_t'(p1_prod_reg[1])
                          + wide_t'(p1_prod_reg[2])) >>> FRAC_BITS;
            end
            v3alu_pkg::OP_CROSS: begin
                for (int k = 0; k < 3; k++) begin
                    wide_r[k] = (wide_t'(p1_prod_reg[2*k])
                              - wide_t'(p1_prod_reg[2*k+1])) >>> FRAC_BITS;
                end
            end
            default: begin
                wide_dot = '0;
            end
        endcase

        for (int k = 0; k < 3; k++) begin
            sat_r[k] = v3alu_pkg::sat32(wide_r[k]);
        end
        sat_dot = v3alu_pkg::sat32(wide_dot);

        side2_next     = '0;
        side2_next.vld = p1_vld_reg;
        side2_next.op  = p1_op_reg;
        side2_next.sc  = p1_s_reg;
        for (int k = 0; k < 3; k++) begin
            side2_next.a[k] = p1_a_reg[k];
            side2_next.r[k] = sat_r[k][W-1:0];
        end
        side2_next.dot = sat_dot[W-1:0];
        side2_next.ov  = sat_r[0][W] | sat_r[1][W] | sat_r[2][W] | sat_dot[W];

        rad_next = $unsigned(p1_prod_reg[0]) + $unsigned(p1_prod_reg[1])
                 + $unsigned(p1_prod_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side2_reg <= '0;
        end else if (ce) begin
            side2_reg <= side2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rad_reg <= rad_next;
        end
    end

    // ---------------- square root ----------------
    v3alu_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (ce),
        .rad_in   (rad_reg),
        .root_out (root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RW; i++) begin
                sidea_reg[i] <= '0;
            end
        end else if (ce) begin
            sidea_reg[0] <= side2_reg;
            for (int i = 1; i < RW; i++) begin
                sidea_reg[i] <= sidea_reg[i-1];
            end
        end
    end

    // ---------------- divisor setup ----------------
    always_comb begin
        sided_next    = sidea_reg[RW-1];
        sided_next.lz = (root == '0);
        for (int k = 0; k < 3; k++) begin
            a_abs[k]    = sidea_reg[RW-1].a[k][W-1] ? (W'(0) - sidea_reg[RW-1].a[k])
                                                    : sidea_reg[RW-1].a[k];
            num_next[k] = {a_abs[k], {FRAC_BITS{1'b0}}};
        end
        s_abs = sidea_reg[RW-1].sc[W-1] ? (W'(0) - sidea_reg[RW-1].sc)
                                        : sidea_reg[RW-1].sc;
        den_next = DN'(1);
        if (sidea_reg[RW-1].op == v3alu_pkg::OP_DIV && sidea_reg[RW-1].sc != '0) begin
            den_next = DN'(s_abs);
        end else if (sidea_reg[RW-1].op == v3alu_pkg::OP_NORM && root != '0) begin
            den_next = DN'(root);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sided_reg <= '0;
        end else if (ce) begin
            sided_reg <= sided_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            den_reg <= den_next;
            for (int k = 0; k < 3; k++) begin
                num_reg[k] <= num_next[k];
            end
        end
    end

    // ---------------- divide ----------------
    for (genvar k = 0; k < 3; k++) begin : g_div
        v3alu_div #(
            .NUM_W (NUM_W)
        ) u_div (
            .aclk    (aclk),
            .en      (ce),
            .num_in  (num_reg[k]),
            .den_in  (den_reg),
            .quo_out (quo[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_W; i++) begin
                sideb_reg[i] <= '0;
            end
        end else if (ce) begin
            sideb_reg[0] <= sided_reg;
            for (int i = 1; i < NUM_W; i++) begin
                sideb_reg[i] <= sideb_reg[i-1];
            end
        end
    end

    // ---------------- result select ----------------
    always_comb begin
        fin = sideb_reg[NUM_W-1];
        for (int k = 0; k < 3; k++) begin
            q_neg = (fin.op == v3alu_pkg::OP_DIV) ? (fin.a[k][W-1] ^ fin.sc[W-1])
                                                  : fin.a[k][W-1];
            if (q_neg) begin
                q_ov[k]  = (|quo[k][NUM_W-1:W]) | (quo[k][W-1] & (|quo[k][W-2:0]));
                q_val[k] = q_ov[k] ? v3alu_pkg::S32_MIN : (W'(0) - quo[k][W-1:0]);
            end else begin
                q_ov[k]  = |quo[k][NUM_W-1:W-1];
                q_val[k] = q_ov[k] ? v3alu_pkg::S32_MAX : quo[k][W-1:0];
            end
        end

        r_next  = fin.r;
        ov_next = fin.ov;
        dz_next = 1'b0;
        if (fin.op == v3alu_pkg::OP_DIV && fin.sc == '0) begin
            dz_next = 1'b1;
            ov_next = 1'b0;
            for (int k = 0; k < 3; k++) begin
                if (fin.a[k][W-1]) begin
                    r_next[k] = v3alu_pkg::S32_MIN;
                end else if (fin.a[k] != '0) begin
                    r_next[k] = v3alu_pkg::S32_MAX;
                end else begin
                    r_next[k] = '0;
                end
            end
        end else if (fin.op == v3alu_pkg::OP_NORM && fin.lz) begin
            r_next  = fin.a;
            ov_next = 1'b0;
        end else if (fin.op == v3alu_pkg::OP_DIV || fin.op == v3alu_pkg::OP_NORM) begin
            r_next  = q_val;
            ov_next = |q_ov;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (ce) begin
            m_vld_reg <= fin.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_r_reg   <= r_next;
            m_dot_reg <= fin.dot;
            m_ov_reg  <= ov_next;
            m_dz_reg  <= dz_next;
        end
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = {m_dot_reg, m_r_reg};
    assign m_axis_tuser  = {m_dz_reg, m_ov_reg};

endmodule

[design/v3alu_checker.sv]
// ----------------------------------------------------------------------------
// v3alu_checker
// Port-level checks for the vector ALU, bound to the top level.
// ----------------------------------------------------------------------------
module v3alu_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result word changed");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input ready while output stalled");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("overflow and divide-by-zero together");

    a_dz_no_dot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[127:96] == 32'd0)
        else $error("dot output nonzero on divide");

endmodule

bind vector3_alu v3alu_checker u_v3alu_checker (.*);

[tb/vector3_alu_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_alu_tb
// Drives directed and random vector operations through the ALU stream ports,
// with random gaps on both sides, and checks every result word against a
// fixed-point predictor of the operation set or a fixed expected word.
// ----------------------------------------------------------------------------
module vector3_alu_tb;

    localparam int FB         = 16;
    localparam int N_RANDOM   = 700;
    localparam int WDOG_LIMIT = 4000;
    localparam int LATENCY    = 68 + FB;

    typedef struct packed {
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rz;
        logic [31:0] dot;
        logic        ov;
        logic        dz;
    } alu_res_t;

    typedef struct {
        v3alu_pkg::op_t op;
        logic [31:0]    a [3];
        logic [31:0]    b [3];
        logic [31:0]    s;
        bit             has_gold;
        alu_res_t       gold;
    } vec_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata;   // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
    logic [2:0]   s_axis_tuser;   // op
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;   // r_x, r_y, r_z, dot_out
    logic [1:0]   m_axis_tuser;   // overflow_flag, div_zero_flag

    alu_res_t  pending_results [$];
    vec_row_t  vec_rows [$];
    int        mismatches;
    int        idle_cycles;
    bit        stim_done;

    vector3_alu #(.FRAC_BITS(FB)) u_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint clamp32(longint v, ref bit ov);
        if (v > 64'sd2147483647) begin
            ov = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            ov = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // exact sum of wide products, floor-shifted and limited to +/-2^62
    function automatic longint fsum(logic signed [127:0] p0, logic signed [127:0] p1,
                                    logic signed [127:0] p2);
        logic signed [127:0] t;
        t = (p0 + p1 + p2) >>> FB;
        if (t > 128'sd4611686018427387904) return 64'sd4611686018427387904;
        if (t < -128'sd4611686018427387904) return -64'sd4611686018427387904;
        return longint'(t);
    endfunction

    function automatic longint root64(logic [127:0] v);
        logic [127:0] res, bitv;
        res = 0;
        bitv = 128'd1 << 126;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic alu_res_t alu_predict(vec_row_t w);
        longint a [3], b [3], r [3];
        longint s, dot, len;
        logic signed [127:0] sq;
        alu_res_t res;
        bit ov;
        bit dz;
        ov = 1'b0;
        dz = 1'b0;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = longint'($signed(w.a[i]));
            b[i] = longint'($signed(w.b[i]));
            r[i] = 0;
        end
        s = longint'($signed(w.s));
        case (w.op)
            v3alu_pkg::OP_ADD:
                for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] + b[i], ov);
            v3alu_pkg::OP_SUB:
                for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] - b[i], ov);
            v3alu_pkg::OP_NEG:
                for (int i = 0; i < 3; i++) r[i] = clamp32(-a[i], ov);
            v3alu_pkg::OP_SCALE:
                for (int i = 0; i < 3; i++) r[i] = clamp32((a[i] * s) >>> FB, ov);
            v3alu_pkg::OP_DOT:
                dot = clamp32(fsum(a[0] * b[0], a[1] * b[1], a[2] * b[2]), ov);
            v3alu_pkg::OP_DIV: begin
                if (s == 0) begin
                    dz = 1'b1;
                    for (int i = 0; i < 3; i++)
                        r[i] = a[i] > 0 ? 64'sd2147483647 :
                               (a[i] < 0 ? -64'sd2147483648 : 0);
                end else begin
                    for (int i = 0; i < 3; i++) r[i] = clamp32((a[i] <<< FB) / s, ov);
                end
            end
            v3alu_pkg::OP_CROSS: begin
                r[0] = clamp32(fsum(a[1] * b[2], -(a[2] * b[1]), 0), ov);
                r[1] = clamp32(fsum(a[2] * b[0], -(a[0] * b[2]), 0), ov);
                r[2] = clamp32(fsum(a[0] * b[1], -(a[1] * b[0]), 0), ov);
            end
            default: begin
                sq = 0;
                for (int i = 0; i < 3; i++) sq = sq + a[i] * a[i];
                len = root64(sq);
                if (len == 0) begin
                    for (int i = 0; i < 3; i++) r[i] = a[i];
                end else begin
                    for (int i = 0; i < 3; i++) r[i] = clamp32((a[i] <<< FB) / len, ov);
                end
            end
        endcase
        res.rx  = r[0][31:0];
        res.ry  = r[1][31:0];
        res.rz  = r[2][31:0];
        res.dot = dot[31:0];
        res.ov  = ov;
        res.dz  = dz;
        return res;
    endfunction

    function automatic vec_row_t mk_row(v3alu_pkg::op_t op, logic [31:0] ax,
                                        logic [31:0] ay, logic [31:0] az,
                                        logic [31:0] bx, logic [31:0] by,
                                        logic [31:0] bz, logic [31:0] s);
        vec_row_t w;
        w.op = op;
        w.a[0] = ax; w.a[1] = ay; w.a[2] = az;
        w.b[0] = bx; w.b[1] = by; w.b[2] = bz;
        w.s = s;
        w.has_gold = 1'b0;
        w.gold = '0;
        return w;
    endfunction

    function automatic vec_row_t mk_gold(vec_row_t w, alu_res_t g);
        w.has_gold = 1'b1;
        w.gold = g;
        return w;
    endfunction

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return v3alu_pkg::S32_MAX;
            1: return v3alu_pkg::S32_MIN;
            2: return 32'($signed($urandom_range(0, 8)) - 4) <<< FB;
            3: return $urandom_range(0, 1) ? 32'(-$urandom_range(0, 32'h0100_0000))
                                             : 32'($urandom_range(0, 32'h0100_0000));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(vec_row_t w);
        alu_res_t g;
        int gap;
        gap = $urandom_range(0, 10);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.op;
        s_axis_tdata  <= {w.s, w.b[2], w.b[1], w.b[0], w.a[2], w.a[1], w.a[0]};
        do @(posedge aclk); while (!s_axis_tready);
        g = alu_predict(w);
        pending_results.push_back(w.has_gold ? w.gold : g);
    endtask

    initial begin
        vec_row_t w;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = v3alu_pkg::OP_ADD;
        stim_done     = 1'b0;

        vec_rows.push_back(mk_gold(mk_row(v3alu_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0), '0));
        vec_rows.push_back(mk_gold(mk_row(v3alu_pkg::OP_ADD, v3alu_pkg::S32_MAX,
                                          v3alu_pkg::S32_MIN, 1, 1, v3alu_pkg::S32_MIN,
                                          2, 0),
                           '{v3alu_pkg::S32_MAX, v3alu_pkg::S32_MIN, 32'd3, 32'd0,
                             1'b1, 1'b0}));
        vec_rows.push_back(mk_gold(mk_row(v3alu_pkg::OP_SUB, v3alu_pkg::S32_MIN,
                                          v3alu_pkg::S32_MAX, 5, 1, v3alu_pkg::S32_MIN,
                                          2, 0),
                           '{v3alu_pkg::S32_MIN, v3alu_pkg::S32_MAX, 32'd3, 32'd0,
                             1'b1, 1'b0}));
        vec_rows.push_back(mk_gold(mk_row(v3alu_pkg::OP_NEG, v3alu_pkg::S32_MIN,
                                          v3alu_pkg::S32_MAX, 0, 0, 0, 0, 0),
                           '{v3alu_pkg::S32_MAX, v3alu_pkg::S32_MIN + 1, 32'd0, 32'd0,
                             1'b1, 1'b0}));
        vec_rows.push_back(mk_gold(mk_row(v3alu_pkg::OP_DIV, v3alu_pkg::S32_MAX,
                                          v3alu_pkg::S32_MIN, 0, 0, 0, 0, 0),
                           '{v3alu_pkg::S32_MAX, v3alu_pkg::S32_MIN, 32'd0, 32'd0,
                             1'b0, 1'b1}));
        vec_rows.push_back(mk_gold(mk_row(v3alu_pkg::OP_NORM, 0, 0, 0, 0, 0, 0, 0), '0));
        vec_rows.push_back(mk_row(v3alu_pkg::OP_NORM, 1, 0, 0, 0, 0, 0, 0));
        vec_rows.push_back(mk_row(v3alu_pkg::OP_NORM, v3alu_pkg::S32_MIN,
                                  v3alu_pkg::S32_MIN, v3alu_pkg::S32_MIN, 0, 0, 0, 0));
        vec_rows.push_back(mk_row(v3alu_pkg::OP_NORM, 32'h0003_0000, 32'h0004_0000, 0,
                                  0, 0, 0, 0));
        vec_rows.push_back(mk_row(v3alu_pkg::OP_SCALE, v3alu_pkg::S32_MIN,
                                  v3alu_pkg::S32_MAX, 32'hffff_ffff, 0, 0, 0,
                                  v3alu_pkg::S32_MIN));
        vec_rows.push_back(mk_row(v3alu_pkg::OP_SCALE, 32'h0002_0000, 32'hfffe_8000, 3,
                                  0, 0, 0, 32'h0001_8000));
        vec_rows.push_back(mk_row(v3alu_pkg::OP_DOT, v3alu_pkg::S32_MIN,
                                  v3alu_pkg::S32_MIN, v3alu_pkg::S32_MIN,
                                  v3alu_pkg::S32_MIN, v3alu_pkg::S32_MIN,
                                  v3alu_pkg::S32_MIN, 0));
        vec_rows.push_back(mk_row(v3alu_pkg::OP_DOT, 32'h0001_0000, 32'h0002_0000,
                                  32'hffff_ffff, 32'h0003_0000, 32'h0004_0000, 1, 0));
        vec_rows.push_back(mk_row(v3alu_pkg::OP_DIV, 32'h0001_0000, 32'hffff_0000, 7,
                                  0, 0, 0, 32'h0000_0003));
        vec_rows.push_back(mk_row(v3alu_pkg::OP_DIV, v3alu_pkg::S32_MIN,
                                  v3alu_pkg::S32_MAX, 1, 0, 0, 0, 32'hffff_ffff));
        vec_rows.push_back(mk_row(v3alu_pkg::OP_CROSS, v3alu_pkg::S32_MAX,
                                  v3alu_pkg::S32_MIN, v3alu_pkg::S32_MAX,
                                  v3alu_pkg::S32_MIN, v3alu_pkg::S32_MAX,
                                  v3alu_pkg::S32_MIN, 0));
        vec_rows.push_back(mk_row(v3alu_pkg::OP_CROSS, 32'h0001_0000, 0, 0, 0,
                                  32'h0001_0000, 0, 0));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (vec_rows[i]) send_word(vec_rows[i]);
        for (int n = 0; n < N_RANDOM; n++) begin
            w = mk_row(v3alu_pkg::op_t'($urandom_range(0, 7)), rand_comp(), rand_comp(),
                       rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                       $urandom_range(0, 7) == 0 ? 32'd0 : rand_comp());
            send_word(w);
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // result side: random stall per word
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        forever begin
            gap = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    always @(posedge aclk) begin
        alu_res_t want, got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                   m_axis_tdata[127:96], m_axis_tuser[0], m_axis_tuser[1]};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: exp %h_%h_%h_%h ov%b dz%b",
                                  " got %h_%h_%h_%h ov%b dz%b"},
                                 want.rx, want.ry, want.rz, want.dot, want.ov, want.dz,
                                 got.rx, got.ry, got.rz, got.dot, got.ov, got.dz);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (stim_done);
        while (pending_results.size() != 0 && idle_cycles < WDOG_LIMIT) @(posedge aclk);
        if (pending_results.size() == 0) repeat (LATENCY + 20) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        wait (idle_cycles >= WDOG_LIMIT && !stim_done);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
